// ===== rtl/utd_pkg.sv =====
`timescale 1ns / 1ps

package utd_pkg;

    localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
    localparam logic [7:0]  LEAD2_LO      = 8'hC2;
    localparam logic [7:0]  LEAD2_HI      = 8'hDF;
    localparam logic [7:0]  LEAD3_LO      = 8'hE0;
    localparam logic [7:0]  LEAD3_HI      = 8'hEF;
    localparam logic [7:0]  LEAD4_LO      = 8'hF0;
    localparam logic [7:0]  LEAD4_HI      = 8'hF4;
    localparam logic [7:0]  LEAD_E0       = 8'hE0;
    localparam logic [7:0]  LEAD_ED       = 8'hED;
    localparam logic [7:0]  LEAD_F0       = 8'hF0;
    localparam logic [7:0]  LEAD_F4       = 8'hF4;
    localparam logic [7:0]  CONT_A0       = 8'hA0;
    localparam logic [7:0]  CONT_9F       = 8'h9F;
    localparam logic [7:0]  CONT_90       = 8'h90;
    localparam logic [7:0]  CONT_8F       = 8'h8F;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [7:0]  lead_byte;
        logic [1:0]  needed_count;
        logic [1:0]  seen_count;
        logic [20:0] partial_point;
    } t_state;

    typedef struct packed {
        logic [1:0] count;
        t_out       unit0;
        t_out       unit1;
    } t_result;

endpackage

// ===== rtl/utd_decode.sv =====
`timescale 1ns / 1ps

module utd_decode import utd_pkg::*; (
    input  t_state  i_state,
    input  t_in     i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic [7:0]  b;
    logic        eos;
    logic        pending;
    logic        cont;
    logic        bad_first;
    logic        brk;
    logic [20:0] pp_next;
    logic [1:0]  seen_next;
    logic [20:0] cp_off;

    logic        lead_has;
    logic [15:0] lead_unit;
    logic        lead_repl;
    t_state      lead_state;

    logic [1:0]  cnt;
    logic [15:0] u0;
    logic [15:0] u1;
    logic        r0;
    logic        r1;

    assign b       = i_item.data_byte;
    assign eos     = i_item.end_of_stream;
    assign pending = (i_state.needed_count != 2'd0);
    assign cont    = (b[7:6] == 2'b10);
    assign bad_first = (i_state.seen_count == 2'd0) && cont &&
        (((i_state.lead_byte == LEAD_E0) && (b < CONT_A0)) ||
         ((i_state.lead_byte == LEAD_ED) && (b > CONT_9F)) ||
         ((i_state.lead_byte == LEAD_F0) && (b < CONT_90)) ||
         ((i_state.lead_byte == LEAD_F4) && (b > CONT_8F)));
    assign brk       = pending && (!cont || bad_first);
    assign pp_next   = {i_state.partial_point[14:0], b[5:0]};
    assign seen_next = i_state.seen_count + 2'd1;
    assign cp_off    = pp_next - SUPP_BASE;

    always_comb begin
        lead_state = '0;
        lead_has   = 1'b1;
        lead_unit  = REPL_UNIT;
        lead_repl  = 1'b1;
        if (b[7] == 1'b0) begin
            lead_unit = {8'd0, b};
            lead_repl = 1'b0;
        end else if ((b >= LEAD2_LO) && (b <= LEAD4_HI)) begin
            if (!eos) begin
                lead_has                 = 1'b0;
                lead_state.lead_byte     = b;
                lead_state.seen_count    = 2'd0;
                if (b <= LEAD2_HI) begin
                    lead_state.needed_count  = 2'd1;
                    lead_state.partial_point = {16'd0, b[4:0]};
                end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
                    lead_state.needed_count  = 2'd2;
                    lead_state.partial_point = {17'd0, b[3:0]};
                end else begin
                    lead_state.needed_count  = 2'd3;
                    lead_state.partial_point = {18'd0, b[2:0]};
                end
            end
        end
    end

    always_comb begin
        o_state = '0;
        cnt     = 2'd0;
        u0      = REPL_UNIT;
        u1      = REPL_UNIT;
        r0      = 1'b1;
        r1      = 1'b1;
        if (!pending) begin
            o_state = lead_state;
            cnt     = {1'b0, lead_has};
            u0      = lead_unit;
            r0      = lead_repl;
        end else if (brk) begin
            o_state = lead_state;
            cnt     = lead_has ? 2'd2 : 2'd1;
            u1      = lead_unit;
            r1      = lead_repl;
        end else if (seen_next >= i_state.needed_count) begin
            if (pp_next[20:16] == 5'd0) begin
                cnt = 2'd1;
                u0  = pp_next[15:0];
                r0  = 1'b0;
            end else begin
                cnt = 2'd2;
                u0  = HI_SURR_BASE | {6'd0, cp_off[19:10]};
                u1  = LO_SURR_BASE | {6'd0, cp_off[9:0]};
                r0  = 1'b0;
                r1  = 1'b0;
            end
        end else if (eos) begin
            cnt = 2'd1;
        end else begin
            o_state               = i_state;
            o_state.seen_count    = seen_next;
            o_state.partial_point = pp_next;
        end
    end

    always_comb begin
        o_result.count                = cnt;
        o_result.unit0.code_unit      = u0;
        o_result.unit0.is_replacement = r0;
        o_result.unit0.last_of_run    = (cnt == 2'd1);
        o_result.unit1.code_unit      = u1;
        o_result.unit1.is_replacement = r1;
        o_result.unit1.last_of_run    = 1'b1;
    end

endmodule

// ===== rtl/utf8_to_utf16_decoder_top.sv =====
`timescale 1ns / 1ps

// UTF-8 to UTF-16 decoder with U+FFFD replacement of malformed input.
// The input channel takes one UTF-8 byte per request together with an
// end-of-stream flag on the last byte of a stream. The output channel gives
// one UTF-16 code unit per request, with a replacement flag and a flag on the
// last unit that a given input byte caused.
// A byte is decoded in the cycle it is accepted; its units appear on the
// output in the next cycle. One byte is taken every cycle as long as each byte
// yields at most one unit and the receiver keeps up. A byte that yields two
// units (a surrogate pair, or a replacement followed by a redecoded lead)
// holds the input until its first unit has drained, since the two-entry output
// buffer drains one unit per cycle while the receiver accepts.
// When the receiver stalls, the buffered units hold steady and the input is
// refused once the buffer cannot take the next byte's units.
// Reset clears the pending sequence and empties the output buffer; the block
// is ready in the first cycle after reset.
module utf8_to_utf16_decoder_top import utd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_state  r_state;
    t_state  n_state;
    t_result dec_result;
    t_out    r_slot0;
    t_out    r_slot1;
    logic [1:0] r_count;
    logic    accept;
    logic    pop;

    utd_decode u_decode (
        .i_state  (r_state),
        .i_item   (i_in_data),
        .o_state  (n_state),
        .o_result (dec_result)
    );

    assign pop         = (r_count != 2'd0) && i_out_ready;
    assign o_in_ready  = (r_count == 2'd0) || ((r_count == 2'd1) && i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_data  = r_slot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
            r_count <= 2'd0;
        end else begin
            if (accept) begin
                r_state <= n_state;
                r_count <= dec_result.count;
            end else if (pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot0 <= dec_result.unit0;
            r_slot1 <= dec_result.unit1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule
